@@ rtl/core/iom_pkg.sv @@
// image orientation remap: shared constants, types and helpers
// no dependencies; used by the channel interfaces and the top level
package iom_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int COORD_W    = $clog2(MAX_DIM);
	localparam int DIM_W      = COORD_W + 1;
	localparam int PIXEL_W    = 32;
	localparam int INDEX_W    = 24;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam int MODE_W     = 3;

	typedef logic [COORD_W-1:0]    coord_t;
	typedef logic [DIM_W-1:0]      dim_t;
	typedef logic [PIXEL_W-1:0]    pixel_t;
	typedef logic [INDEX_W-1:0]    index_t;
	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE       = 3'd0,
		MODE_FLIP_H     = 3'd1,
		MODE_ROT180     = 3'd2,
		MODE_FLIP_V     = 3'd3,
		MODE_TRANSPOSE  = 3'd4,
		MODE_ROT90      = 3'd5,
		MODE_TRANSVERSE = 3'd6,
		MODE_ROT270     = 3'd7
	} orient_mode_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_NONE   = 2'd3
	} reg_index_t;

	// zero is taken as one, anything above the maximum saturates
	function automatic dim_t clamp_dim(input cfg_data_t v);
		dim_t r;
		if (v == '0) begin
			r = dim_t'(1);
		end else if (v > cfg_data_t'(MAX_DIM)) begin
			r = dim_t'(MAX_DIM);
		end else begin
			r = dim_t'(v);
		end
		return r;
	endfunction

endpackage

@@ rtl/core/iom_cfg_if.sv @@
// configuration write channel: register index and write data
// depends on iom_pkg
interface iom_cfg_if;
	import iom_pkg::*;

	logic      valid;
	logic      ready;
	cfg_addr_t index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/iom_pixel_if.sv @@
// source pixel channel: one 32-bit pixel per item
// depends on iom_pkg
interface iom_pixel_if;
	import iom_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

@@ rtl/core/iom_result_if.sv @@
// result channel: pixel with its destination position and frame end flag
// depends on iom_pkg
interface iom_result_if;
	import iom_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t pixel_out;
	coord_t dest_col;
	coord_t dst_row;
	index_t dest_index;
	logic   frame_end;

	modport source (output valid, output pixel_out, output dest_col, output dst_row,
		output dest_index, output frame_end, input ready);
	modport sink (input valid, input pixel_out, input dest_col, input dst_row,
		input dest_index, input frame_end, output ready);
endinterface

@@ rtl/core/image_orientation_remap.sv @@
// image orientation remap: top level, two register stages
// a pixel accepted into the input register leaves as a result from the output register
// throughput: one pixel per cycle unless results stall; input register feeds the remap and
// index multiply-add, whose result sits in the output register
// reset: counters at 0, mode none, width and height 1, both stages empty
// depends on iom_pkg, iom_cfg_if, iom_pixel_if, iom_result_if
module image_orientation_remap (
	input  logic         clk,
	input  logic         arst_n,
	iom_cfg_if.sink      cfg,
	iom_pixel_if.sink    pixels,
	iom_result_if.source results
);
	import iom_pkg::*;

	localparam int PROD_W = COORD_W + DIM_W;

	orient_mode_t mode_q;
	dim_t         width_q;
	dim_t         height_q;
	coord_t       col_q;
	coord_t       row_q;

	logic   valid_s1;
	pixel_t pixel_s1;
	coord_t x_s1;
	coord_t y_s1;
	logic   last_s1;

	logic   valid_s2;
	pixel_t pixel_s2;
	coord_t col_s2;
	coord_t row_s2;
	index_t index_s2;
	logic   last_s2;

	logic   accept;
	logic   adv_s2;
	coord_t x_cur;
	coord_t y_cur;
	logic   last_col;
	logic   last_row;
	dim_t   wm1;
	dim_t   hm1;
	coord_t rx;
	coord_t ry;
	coord_t dc;
	coord_t dr;
	dim_t   dw;
	logic [PROD_W-1:0] idx_full;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NONE;
			width_q  <= dim_t'(1);
			height_q <= dim_t'(1);
		end else if (cfg.valid) begin
			unique case (reg_index_t'(cfg.index))
				REG_MODE:   mode_q   <= orient_mode_t'(cfg.data[MODE_W-1:0]);
				REG_WIDTH:  width_q  <= clamp_dim(cfg.data);
				REG_HEIGHT: height_q <= clamp_dim(cfg.data);
				default:    ;
			endcase
		end
	end

	assign wm1 = width_q - dim_t'(1);
	assign hm1 = height_q - dim_t'(1);

	// counters past the frame after a shrink restart at zero
	assign x_cur    = ({1'b0, col_q} < width_q) ? col_q : '0;
	assign y_cur    = ({1'b0, row_q} < height_q) ? row_q : '0;
	assign last_col = ({1'b0, x_cur} == wm1);
	assign last_row = ({1'b0, y_cur} == hm1);

	assign adv_s2       = !valid_s2 || results.ready;
	assign pixels.ready = !valid_s1 || adv_s2;
	assign accept       = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : y_cur + coord_t'(1);
				end else begin
					col_q <= x_cur + coord_t'(1);
					row_q <= y_cur;
				end
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixels.pixel;
			x_s1     <= x_cur;
			y_s1     <= y_cur;
			last_s1  <= last_col && last_row;
		end
	end

	// mirrored coordinates stay in range since x < width and y < height
	assign rx = wm1[COORD_W-1:0] - x_s1;
	assign ry = hm1[COORD_W-1:0] - y_s1;

	always_comb begin
		unique case (mode_q)
			MODE_NONE:       begin dc = x_s1; dr = y_s1; dw = width_q;  end
			MODE_FLIP_H:     begin dc = rx;   dr = y_s1; dw = width_q;  end
			MODE_ROT180:     begin dc = rx;   dr = ry;   dw = width_q;  end
			MODE_FLIP_V:     begin dc = x_s1; dr = ry;   dw = width_q;  end
			MODE_TRANSPOSE:  begin dc = y_s1; dr = x_s1; dw = height_q; end
			MODE_ROT90:      begin dc = ry;   dr = x_s1; dw = height_q; end
			MODE_TRANSVERSE: begin dc = ry;   dr = rx;   dw = height_q; end
			MODE_ROT270:     begin dc = y_s1; dr = rx;   dw = height_q; end
			default:         begin dc = x_s1; dr = y_s1; dw = width_q;  end
		endcase
	end

	assign idx_full = PROD_W'(dr) * PROD_W'(dw) + PROD_W'(dc);

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_s2 <= pixel_s1;
			col_s2   <= dc;
			row_s2   <= dr;
			index_s2 <= idx_full[INDEX_W-1:0];
			last_s2  <= last_s1;
		end
	end

	assign results.valid      = valid_s2;
	assign results.pixel_out  = pixel_s2;
	assign results.dest_col   = col_s2;
	assign results.dst_row    = row_s2;
	assign results.dest_index = index_s2;
	assign results.frame_end  = last_s2;

endmodule
